// File: rtl/cmbd_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helpers of the calculator memory bus decoder.
package cmbd_pkg;

   // Default sizes of the two large stores.
   localparam int RAM_BYTES_DEFAULT = 262144;
   localparam int ROM_BYTES_DEFAULT = 1048576;

   // IO register file: 32 addressable registers and four overflow entries.
   localparam int IO_BYTES         = 32;
   localparam int IO_STORE_DEPTH   = IO_BYTES + 4;
   localparam int IO_INDEX_WIDTH   = $clog2(IO_STORE_DEPTH);
   localparam int IO_OFFSET_WIDTH  = $clog2(IO_BYTES);

   localparam logic [23:0] IO_BASE        = 24'h600000;
   localparam logic [23:0] RAM_MASK_SMALL = 24'h01FFFF;
   localparam logic [23:0] RAM_MASK_LARGE = 24'h03FFFF;

   // Bank codes, address bits 23 to 21.
   localparam logic [2:0] BANK_RAM    = 3'd0;
   localparam logic [2:0] BANK_ROM_LO = 3'd1;
   localparam logic [2:0] BANK_ROM_HI = 3'd2;

   // Commands and access sizes.
   localparam logic       CMD_WRITE  = 1'b1;
   localparam logic [1:0] SIZE_BYTE  = 2'd0;
   localparam logic [1:0] SIZE_WORD  = 2'd1;

   // IO register numbers with special behaviour.
   localparam logic [IO_INDEX_WIDTH-1:0] IO_REG_STATUS      = 6'h00;
   localparam logic [IO_INDEX_WIDTH-1:0] IO_REG_MEMORY_CFG  = 6'h01;
   localparam logic [IO_INDEX_WIDTH-1:0] IO_REG_INTERRUPT   = 6'h0c;
   localparam logic [IO_INDEX_WIDTH-1:0] IO_REG_LINK_STATUS = 6'h0d;
   localparam logic [IO_INDEX_WIDTH-1:0] IO_REG_LINK_DATA   = 6'h0f;
   localparam logic [IO_INDEX_WIDTH-1:0] IO_REG_SCREEN_LO   = 6'h10;
   localparam logic [IO_INDEX_WIDTH-1:0] IO_REG_SCREEN_HI   = 6'h11;
   localparam logic [IO_INDEX_WIDTH-1:0] IO_REG_TIMER       = 6'h17;
   localparam logic [IO_INDEX_WIDTH-1:0] IO_REG_ON_KEY      = 6'h1a;
   localparam logic [IO_INDEX_WIDTH-1:0] IO_REG_KEYBOARD    = 6'h1b;
   localparam logic [IO_INDEX_WIDTH-1:0] IO_REG_CONTRAST    = 6'h1d;

   // Values returned by patched IO registers.
   localparam logic [7:0] STATUS_FIXED_BITS  = 8'h04;
   localparam logic [7:0] LINK_STATUS_READY  = 8'h60;
   localparam logic [7:0] LINK_STATUS_IDLE   = 8'h40;
   localparam logic [7:0] ON_KEY_RELEASED    = 8'h02;
   localparam logic [7:0] ON_KEY_PRESSED     = 8'h00;

   // Configuration register port.
   localparam int CSR_INDEX_WIDTH = 1;
   localparam int CSR_DATA_WIDTH  = 20;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_RAM_IS_SMALL     = 1'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ROM_ADDRESS_MASK = 1'd1;

   typedef struct packed {
      logic        command;
      logic [1:0]  access_size;
      logic [23:0] address;
      logic [31:0] write_data;
      logic        link_rx_ready;
      logic [7:0]  link_rx_byte;
      logic        on_key_down;
      logic [7:0]  keyboard_mask;
   } req_type;

   typedef struct packed {
      logic [31:0] read_data;
      logic        address_error;
      logic        raise_interrupt_four;
      logic        link_tx_valid;
      logic [7:0]  link_tx_byte;
      logic        link_rx_taken;
      logic        timer_write_valid;
      logic [7:0]  timer_write_value;
      logic        contrast_changed;
      logic        screen_base_changed;
   } rsp_type;

   typedef enum logic [1:0] {
      TGT_RAM = 2'd0,
      TGT_ROM = 2'd1,
      TGT_IO  = 2'd2
   } target_type;

   typedef enum logic [2:0] {
      PATCH_NONE        = 3'd0,
      PATCH_STATUS      = 3'd1,
      PATCH_MEMORY_CFG  = 3'd2,
      PATCH_LINK_STATUS = 3'd3,
      PATCH_LINK_RX     = 3'd4,
      PATCH_ON_KEY      = 3'd5,
      PATCH_KEYBOARD    = 3'd6
   } patch_type;

   // Decoded view of one byte of an access.
   typedef struct packed {
      target_type                target;
      logic [IO_INDEX_WIDTH-1:0] io_index;
      logic [7:0]                wr_byte;
      logic                      store;
      patch_type                 patch;
      logic                      irq4;
      logic                      tx;
      logic                      rx_taken;
      logic                      tm;
      logic                      contrast;
      logic                      screen;
   } byte_op_type;

   // Index of the last byte of an access; size code three counts as long.
   function automatic logic [1:0] last_byte(input logic [1:0] size);
      logic [1:0] result;
      case (size)
         SIZE_BYTE: result = 2'd0;
         SIZE_WORD: result = 2'd1;
         default:   result = 2'd3;
      endcase
      return result;
   endfunction

endpackage

// File: rtl/calculator_memory_bus_decoder_unit.sv
`timescale 1ns / 1ps
// Top level of the calculator memory bus decoder.
//
// The block serves one big-endian bus transaction at a time: a byte, word or
// long read or write at a 24-bit address, into RAM (bank 0), ROM (banks 1
// and 2, writable) or the IO register file (0x600000 and up). Each store is
// a single-port synchronous RAM with a registered read, and the unit walks
// through the bytes of a transaction one per cycle, since every byte may land
// in a different store or bank. A word or long at an odd address is
// answered with an address error and touches no store. The accept state is
// followed by the access state, which handles the bytes in turn, a drain
// state that collects the last read byte and a result state that loads the
// result register; a new request may be accepted while the previous result
// is still waiting to be taken. RAM and ROM contents are undefined until
// written and are never cleared. The IO register file resets to zero
// through a valid bit per entry, so no clearing pass is needed and the
// block is ready straight after reset. Configuration writes are accepted in
// any cycle but must only be issued while no transaction is in progress.
module calculator_memory_bus_decoder_unit #(
   parameter int RAM_BYTES = cmbd_pkg::RAM_BYTES_DEFAULT,
   parameter int ROM_BYTES = cmbd_pkg::ROM_BYTES_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  cmbd_pkg::req_type                    req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output cmbd_pkg::rsp_type                    rsp_data,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [cmbd_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [cmbd_pkg::CSR_DATA_WIDTH-1:0]  csr_data
);

   localparam int RAM_AW = $clog2(RAM_BYTES);
   localparam int ROM_AW = $clog2(ROM_BYTES);
   localparam int IO_AW  = cmbd_pkg::IO_INDEX_WIDTH;

   // Sequencer states, one-hot.
   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_ACCESS = 4'b0010,
      ST_DRAIN  = 4'b0100,
      ST_RESULT = 4'b1000
   } state_type;

   // Side effects gathered over the bytes of one transaction.
   typedef struct packed {
      logic       irq4;
      logic       tx_valid;
      logic [7:0] tx_byte;
      logic       rx_taken;
      logic       tm_valid;
      logic [7:0] tm_value;
      logic       contrast;
      logic       screen;
   } side_type;

   // A read byte whose data arrives from a store in the following cycle.
   typedef struct packed {
      logic                 valid;
      cmbd_pkg::target_type target;
      cmbd_pkg::patch_type  patch;
      logic                 io_valid;
   } pend_type;

   state_type         state_ff, state_in;
   cmbd_pkg::req_type req_ff, req_in;
   logic [1:0]        byte_ff, byte_in;
   logic [31:0]       rd_ff, rd_in;
   logic              err_ff, err_in;
   side_type          side_ff, side_in;
   pend_type          pend_ff, pend_in;
   logic [cmbd_pkg::IO_STORE_DEPTH-1:0] io_valid_ff, io_valid_in;
   cmbd_pkg::rsp_type rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              ram_is_small_ff, ram_is_small_in;
   logic [cmbd_pkg::CSR_DATA_WIDTH-1:0] rom_mask_ff, rom_mask_in;

   cmbd_pkg::byte_op_type op;
   logic [RAM_AW-1:0] ram_index;
   logic [ROM_AW-1:0] rom_index;
   logic [7:0]        ram_rd, rom_rd, io_rd;
   logic              ram_en, rom_en, io_en, mem_we;
   logic              accessing;
   logic [7:0]        raw_byte, read_byte;
   logic              slot_free;

   cmbd_decode #(
      .RAM_BYTES (RAM_BYTES),
      .ROM_BYTES (ROM_BYTES)
   ) u_decode (
      .req              (req_ff),
      .byte_sel         (byte_ff),
      .ram_is_small     (ram_is_small_ff),
      .rom_address_mask (rom_mask_ff),
      .op               (op),
      .ram_index        (ram_index),
      .rom_index        (rom_index)
   );

   // Memory enables: one byte goes to at most one store per cycle.
   assign accessing = (state_ff == ST_ACCESS);
   assign mem_we    = (req_ff.command == cmbd_pkg::CMD_WRITE);
   assign ram_en    = accessing && (op.target == cmbd_pkg::TGT_RAM);
   assign rom_en    = accessing && (op.target == cmbd_pkg::TGT_ROM);
   assign io_en     = accessing && (op.target == cmbd_pkg::TGT_IO)
                      && (!mem_we || op.store);

   cmbd_ram #(
      .WIDTH (8),
      .DEPTH (RAM_BYTES)
   ) u_main_ram (
      .clock   (clock),
      .en      (ram_en),
      .we      (mem_we),
      .addr    (ram_index),
      .wr_data (op.wr_byte),
      .rd_data (ram_rd)
   );

   cmbd_ram #(
      .WIDTH (8),
      .DEPTH (ROM_BYTES)
   ) u_rom_store (
      .clock   (clock),
      .en      (rom_en),
      .we      (mem_we),
      .addr    (rom_index),
      .wr_data (op.wr_byte),
      .rd_data (rom_rd)
   );

   cmbd_ram #(
      .WIDTH (8),
      .DEPTH (cmbd_pkg::IO_STORE_DEPTH)
   ) u_io_registers (
      .clock   (clock),
      .en      (io_en),
      .we      (mem_we),
      .addr    (op.io_index[IO_AW-1:0]),
      .wr_data (op.wr_byte),
      .rd_data (io_rd)
   );

   // Read data of the byte issued last cycle, with the IO patches applied.
   // The patch inputs come from the captured request, which holds until the
   // transaction is finished.
   always_comb begin
      case (pend_ff.target)
         cmbd_pkg::TGT_RAM: raw_byte = ram_rd;
         cmbd_pkg::TGT_ROM: raw_byte = rom_rd;
         default:           raw_byte = pend_ff.io_valid ? io_rd : 8'h00;
      endcase

      case (pend_ff.patch)
         cmbd_pkg::PATCH_STATUS:
            read_byte = raw_byte | cmbd_pkg::STATUS_FIXED_BITS;
         cmbd_pkg::PATCH_MEMORY_CFG:
            read_byte = {raw_byte[7:1], ram_is_small_ff};
         cmbd_pkg::PATCH_LINK_STATUS:
            read_byte = req_ff.link_rx_ready ? cmbd_pkg::LINK_STATUS_READY
                                             : cmbd_pkg::LINK_STATUS_IDLE;
         cmbd_pkg::PATCH_LINK_RX:
            read_byte = req_ff.link_rx_byte;
         cmbd_pkg::PATCH_ON_KEY:
            read_byte = req_ff.on_key_down ? cmbd_pkg::ON_KEY_PRESSED
                                           : cmbd_pkg::ON_KEY_RELEASED;
         cmbd_pkg::PATCH_KEYBOARD:
            read_byte = req_ff.keyboard_mask;
         default:
            read_byte = raw_byte;
      endcase
   end

   assign slot_free = !rsp_valid_ff || rsp_ready;

   // Sequencer and datapath next-state logic.
   always_comb begin
      state_in        = state_ff;
      req_in          = req_ff;
      byte_in         = byte_ff;
      rd_in           = rd_ff;
      err_in          = err_ff;
      side_in         = side_ff;
      pend_in         = pend_ff;
      pend_in.valid   = 1'b0;
      io_valid_in     = io_valid_ff;
      rsp_in          = rsp_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      ram_is_small_in = ram_is_small_ff;
      rom_mask_in     = rom_mask_ff;

      if (csr_valid) begin
         case (csr_index)
            cmbd_pkg::CSR_RAM_IS_SMALL:     ram_is_small_in = csr_data[0];
            cmbd_pkg::CSR_ROM_ADDRESS_MASK: rom_mask_in     = csr_data;
            default: ;
         endcase
      end

      // Big-endian assembly: earlier bytes move up as later ones arrive.
      if (pend_ff.valid) begin
         rd_in = {rd_ff[23:0], read_byte};
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in  = req_data;
               byte_in = 2'd0;
               rd_in   = 32'd0;
               side_in = '0;
               err_in  = (cmbd_pkg::last_byte(req_data.access_size) != 2'd0)
                         && req_data.address[0];
               state_in = err_in ? ST_RESULT : ST_ACCESS;
            end
         end
         ST_ACCESS: begin
            byte_in = byte_ff + 2'd1;

            if (mem_we) begin
               if (op.target == cmbd_pkg::TGT_IO && op.store) begin
                  io_valid_in[op.io_index] = 1'b1;
               end
            end else begin
               pend_in.valid    = 1'b1;
               pend_in.target   = op.target;
               pend_in.patch    = op.patch;
               pend_in.io_valid = io_valid_ff[op.io_index];
            end

            side_in.irq4     = side_ff.irq4 | op.irq4;
            side_in.rx_taken = side_ff.rx_taken | op.rx_taken;
            side_in.contrast = side_ff.contrast | op.contrast;
            side_in.screen   = side_ff.screen | op.screen;
            if (op.tx) begin
               side_in.tx_valid = 1'b1;
               side_in.tx_byte  = op.wr_byte;
            end
            if (op.tm) begin
               side_in.tm_valid = 1'b1;
               side_in.tm_value = op.wr_byte;
            end

            if (byte_ff == cmbd_pkg::last_byte(req_ff.access_size)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_RESULT;
         end
         ST_RESULT: begin
            if (slot_free) begin
               rsp_in.read_data            = rd_ff;
               rsp_in.address_error        = err_ff;
               rsp_in.raise_interrupt_four = side_ff.irq4;
               rsp_in.link_tx_valid        = side_ff.tx_valid;
               rsp_in.link_tx_byte         = side_ff.tx_byte;
               rsp_in.link_rx_taken        = side_ff.rx_taken;
               rsp_in.timer_write_valid    = side_ff.tm_valid;
               rsp_in.timer_write_value    = side_ff.tm_value;
               rsp_in.contrast_changed     = side_ff.contrast;
               rsp_in.screen_base_changed  = side_ff.screen;
               rsp_valid_in                = 1'b1;
               state_in                    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         pend_ff         <= '0;
         io_valid_ff     <= '0;
         rsp_valid_ff    <= 1'b0;
         ram_is_small_ff <= 1'b0;
         rom_mask_ff     <= '1;
      end else begin
         state_ff        <= state_in;
         pend_ff         <= pend_in;
         io_valid_ff     <= io_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
         ram_is_small_ff <= ram_is_small_in;
         rom_mask_ff     <= rom_mask_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      req_ff  <= req_in;
      byte_ff <= byte_in;
      rd_ff   <= rd_in;
      err_ff  <= err_in;
      side_ff <= side_in;
      rsp_ff  <= rsp_in;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign csr_ready = 1'b1;

endmodule

// File: rtl/cmbd_ram.sv
`timescale 1ns / 1ps
// Generic single-port synchronous RAM with a registered read.
module cmbd_ram #(
   parameter  int WIDTH = 8,
   parameter  int DEPTH = 256,
   localparam int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             en,
   input  logic             we,
   input  logic [AW-1:0]    addr,
   input  logic [WIDTH-1:0] wr_data,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] storage_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            storage_ff[addr] <= wr_data;
         end else begin
            rd_data_ff <= storage_ff[addr];
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/cmbd_decode.sv
`timescale 1ns / 1ps
// Per-byte address decode: target store, index, write byte and IO side effects.
module cmbd_decode #(
   parameter  int RAM_BYTES = cmbd_pkg::RAM_BYTES_DEFAULT,
   parameter  int ROM_BYTES = cmbd_pkg::ROM_BYTES_DEFAULT,
   localparam int RAM_AW    = $clog2(RAM_BYTES),
   localparam int ROM_AW    = $clog2(ROM_BYTES)
) (
   input  cmbd_pkg::req_type                       req,
   input  logic [1:0]                              byte_sel,
   input  logic                                    ram_is_small,
   input  logic [cmbd_pkg::CSR_DATA_WIDTH-1:0]     rom_address_mask,
   output cmbd_pkg::byte_op_type                   op,
   output logic [RAM_AW-1:0]                       ram_index,
   output logic [ROM_AW-1:0]                       rom_index
);

   logic [1:0]  lane;
   logic [23:0] byte_addr;
   logic [23:0] ram_full;
   logic [23:0] rom_full;
   logic [cmbd_pkg::IO_INDEX_WIDTH-1:0] io_idx;
   logic        is_write;

   always_comb begin
      lane      = cmbd_pkg::last_byte(req.access_size) - byte_sel;
      byte_addr = req.address + {22'd0, byte_sel};
      ram_full  = byte_addr & (ram_is_small ? cmbd_pkg::RAM_MASK_SMALL
                                            : cmbd_pkg::RAM_MASK_LARGE);
      rom_full  = byte_addr & {4'd0, rom_address_mask};
      is_write  = (req.command == cmbd_pkg::CMD_WRITE);
      io_idx    = {1'b0, req.address[cmbd_pkg::IO_OFFSET_WIDTH-1:0]}
                  + {4'd0, byte_sel};

      op          = '0;
      op.target   = cmbd_pkg::TGT_IO;
      op.patch    = cmbd_pkg::PATCH_NONE;
      op.wr_byte  = req.write_data[{lane, 3'b000} +: 8];
      op.store    = 1'b1;

      if (req.address >= cmbd_pkg::IO_BASE) begin
         op.io_index = io_idx;
         if (is_write) begin
            case (io_idx)
               cmbd_pkg::IO_REG_INTERRUPT: op.irq4 = op.wr_byte[1];
               cmbd_pkg::IO_REG_LINK_DATA: begin
                  op.tx    = 1'b1;
                  op.store = 1'b0;
               end
               cmbd_pkg::IO_REG_TIMER: begin
                  op.tm    = 1'b1;
                  op.store = 1'b0;
               end
               cmbd_pkg::IO_REG_CONTRAST: op.contrast = 1'b1;
               default: begin
                  op.screen = io_idx inside {cmbd_pkg::IO_REG_SCREEN_LO,
                                             cmbd_pkg::IO_REG_SCREEN_HI};
               end
            endcase
         end else begin
            case (io_idx)
               cmbd_pkg::IO_REG_STATUS:      op.patch = cmbd_pkg::PATCH_STATUS;
               cmbd_pkg::IO_REG_MEMORY_CFG:  op.patch = cmbd_pkg::PATCH_MEMORY_CFG;
               cmbd_pkg::IO_REG_LINK_STATUS: op.patch = cmbd_pkg::PATCH_LINK_STATUS;
               cmbd_pkg::IO_REG_LINK_DATA: begin
                  op.patch    = cmbd_pkg::PATCH_LINK_RX;
                  op.rx_taken = 1'b1;
               end
               cmbd_pkg::IO_REG_ON_KEY:      op.patch = cmbd_pkg::PATCH_ON_KEY;
               cmbd_pkg::IO_REG_KEYBOARD:    op.patch = cmbd_pkg::PATCH_KEYBOARD;
               default:                      op.patch = cmbd_pkg::PATCH_NONE;
            endcase
         end
      end else begin
         // Memory path: each byte is decoded on its own address, so a long
         // access may straddle two banks or reach the IO file unpatched.
         if (byte_addr[23:21] == cmbd_pkg::BANK_RAM) begin
            op.target = cmbd_pkg::TGT_RAM;
         end else if (byte_addr[23:21] inside {cmbd_pkg::BANK_ROM_LO,
                                                cmbd_pkg::BANK_ROM_HI}) begin
            op.target = cmbd_pkg::TGT_ROM;
         end else begin
            op.io_index = {1'b0, byte_addr[cmbd_pkg::IO_OFFSET_WIDTH-1:0]};
         end
      end

      ram_index = ram_full[RAM_AW-1:0];
      rom_index = rom_full[ROM_AW-1:0];
   end

endmodule

// File: rtl/cmbd_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the bus decoder, bound to the top level.
module cmbd_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input cmbd_pkg::rsp_type rsp_data
);

   // A held result must not change while the consumer stalls.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // Only one transaction is in progress at a time.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while busy");

   // An address error touches nothing and returns zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.address_error |->
         rsp_data.read_data == 32'd0 && !rsp_data.raise_interrupt_four &&
         !rsp_data.link_tx_valid && !rsp_data.link_rx_taken &&
         !rsp_data.timer_write_valid && !rsp_data.contrast_changed &&
         !rsp_data.screen_base_changed)
      else $error("address error with side effects");

   // Data bytes of write side effects stay zero when not flagged.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         (rsp_data.link_tx_valid || rsp_data.link_tx_byte == 8'd0) &&
         (rsp_data.timer_write_valid || rsp_data.timer_write_value == 8'd0))
      else $error("stale side-effect byte");

   // A link receive is a read, so no write side effect may accompany it.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.link_rx_taken |->
         !rsp_data.link_tx_valid && !rsp_data.timer_write_valid &&
         !rsp_data.contrast_changed && !rsp_data.screen_base_changed &&
         !rsp_data.raise_interrupt_four)
      else $error("read and write side effects mixed");

endmodule

bind calculator_memory_bus_decoder_unit cmbd_checker u_cmbd_checker (.*);

// File: tb/tb_calculator_memory_bus_decoder_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench of the calculator memory bus decoder unit.
module tb_calculator_memory_bus_decoder_unit;

   // Store sizes follow the defaults that the unit is built with.
   localparam int RAM_IMAGE_BYTES = cmbd_pkg::RAM_BYTES_DEFAULT;
   localparam int ROM_IMAGE_BYTES = cmbd_pkg::ROM_BYTES_DEFAULT;

   // Codes that the package leaves unnamed.
   localparam logic       CMD_READ   = 1'b0;
   localparam logic [1:0] SIZE_LONG  = 2'd2;
   localparam logic [1:0] SIZE_THREE = 2'd3;

   localparam int RESET_CYCLES     = 5;
   localparam int PHASES           = 6;
   localparam int RANDOM_PER_PHASE = 175;
   localparam int SETTLE_CYCLES    = 8;
   localparam int HOLD_AFTER       = 100;
   localparam int HOLD_CYCLES      = 80;
   localparam int WATCHDOG_LIMIT   = 3000;
   localparam int MAX_REPORTS      = 200;
   localparam int RECENT_DEPTH     = 48;

   // Where a byte of an access lands: the store and the index within it.
   typedef struct packed {
      cmbd_pkg::target_type tgt;
      logic [19:0]          idx;
   } slot_type;

   logic                                 clock = 1'b0;
   logic                                 reset = 1'b1;
   logic                                 req_valid = 1'b0;
   logic                                 req_ready;
   cmbd_pkg::req_type                    req_data = '0;
   logic                                 rsp_valid;
   logic                                 rsp_ready = 1'b0;
   cmbd_pkg::rsp_type                    rsp_data;
   logic                                 csr_valid = 1'b0;
   logic                                 csr_ready;
   logic [cmbd_pkg::CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [cmbd_pkg::CSR_DATA_WIDTH-1:0]  csr_data = '0;

   calculator_memory_bus_decoder_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Transactions waiting to be offered, and the responses that the accepted
   // ones are due to produce, oldest first.
   cmbd_pkg::req_type  bus_requests [$];
   cmbd_pkg::rsp_type  due_results [$];

   // Image of the unit's stores and configuration, advanced as transactions
   // and register writes are accepted.
   bit [7:0]    ram_image [RAM_IMAGE_BYTES];
   bit [7:0]    rom_image [ROM_IMAGE_BYTES];
   bit [7:0]    io_image [cmbd_pkg::IO_STORE_DEPTH];
   logic        model_ram_small = 1'b0;
   logic [19:0] model_rom_mask  = 20'hFFFFF;

   // The stimulus side keeps its own record of which RAM and ROM bytes have
   // been written, so that no read ever touches a byte whose content is
   // undefined. It also keeps the configuration that it has planned.
   bit          ram_filled [RAM_IMAGE_BYTES];
   bit          rom_filled [ROM_IMAGE_BYTES];
   logic        plan_ram_small = 1'b0;
   logic [19:0] plan_rom_mask  = 20'hFFFFF;
   logic [23:0] recent_writes [$];

   int send_idle_pct   = 0;
   int recv_idle_pct   = 0;
   int items_made      = 0;
   int items_accepted  = 0;
   int results_checked = 0;
   int mismatch_count  = 0;
   int csr_writes      = 0;
   int errors_seen     = 0;
   int side_effects    = 0;
   int quiet_cycles    = 0;
   int hold_left       = 0;
   bit hold_started    = 1'b0;

   function automatic int byte_count(logic [1:0] size);
      case (size)
         cmbd_pkg::SIZE_BYTE: return 1;
         cmbd_pkg::SIZE_WORD: return 2;
         default:             return 4;
      endcase
   endfunction

   // Bank decode of one byte address below the IO window. Bank three can
   // only be reached here by a long that starts just under 0x600000.
   function automatic slot_type locate(logic [23:0] a, logic ram_small,
                                       logic [19:0] rom_mask);
      slot_type s;
      case (a[23:21])
         cmbd_pkg::BANK_RAM: begin
            s.tgt = cmbd_pkg::TGT_RAM;
            s.idx = 20'(a & (ram_small ? cmbd_pkg::RAM_MASK_SMALL : cmbd_pkg::RAM_MASK_LARGE)
                        & 24'(RAM_IMAGE_BYTES - 1));
         end
         cmbd_pkg::BANK_ROM_LO, cmbd_pkg::BANK_ROM_HI: begin
            s.tgt = cmbd_pkg::TGT_ROM;
            s.idx = a[19:0] & rom_mask & 20'(ROM_IMAGE_BYTES - 1);
         end
         default: begin
            s.tgt = cmbd_pkg::TGT_IO;
            s.idx = 20'(a[cmbd_pkg::IO_OFFSET_WIDTH-1:0]);
         end
      endcase
      return s;
   endfunction

   // Works out the response of one bus transaction and applies its writes to
   // the store images. Every byte is handled on its own address, most
   // significant byte first.
   function automatic cmbd_pkg::rsp_type serve_access(cmbd_pkg::req_type r);
      cmbd_pkg::rsp_type                   o;
      logic [31:0]                         rd;
      logic [7:0]                          wb;
      logic [7:0]                          rb;
      logic [cmbd_pkg::IO_INDEX_WIDTH-1:0] io_idx;
      slot_type                            s;
      int                                  n;
      int                                  flat;
      bit                                  keep;
      o  = '0;
      rd = '0;
      n  = byte_count(r.access_size);
      if (n > 1 && r.address[0]) begin
         o.address_error = 1'b1;
      end else if (r.address >= cmbd_pkg::IO_BASE) begin
         for (int k = 0; k < n; k++) begin
            flat   = (int'(r.address[cmbd_pkg::IO_OFFSET_WIDTH-1:0]) + k)
                     % cmbd_pkg::IO_STORE_DEPTH;
            io_idx = flat[cmbd_pkg::IO_INDEX_WIDTH-1:0];
            wb     = r.write_data[8*(n-1-k) +: 8];
            if (r.command == cmbd_pkg::CMD_WRITE) begin
               keep = 1'b1;
               case (io_idx)
                  cmbd_pkg::IO_REG_INTERRUPT: if (wb[1]) o.raise_interrupt_four = 1'b1;
                  cmbd_pkg::IO_REG_LINK_DATA: begin
                     o.link_tx_valid = 1'b1;
                     o.link_tx_byte  = wb;
                     keep = 1'b0;
                  end
                  cmbd_pkg::IO_REG_TIMER: begin
                     o.timer_write_valid = 1'b1;
                     o.timer_write_value = wb;
                     keep = 1'b0;
                  end
                  cmbd_pkg::IO_REG_CONTRAST: o.contrast_changed = 1'b1;
                  cmbd_pkg::IO_REG_SCREEN_LO, cmbd_pkg::IO_REG_SCREEN_HI:
                     o.screen_base_changed = 1'b1;
                  default: ;
               endcase
               if (keep) io_image[io_idx] = wb;
            end else begin
               case (io_idx)
                  cmbd_pkg::IO_REG_STATUS:
                     rb = io_image[cmbd_pkg::IO_REG_STATUS] | cmbd_pkg::STATUS_FIXED_BITS;
                  cmbd_pkg::IO_REG_MEMORY_CFG:
                     rb = model_ram_small ? (io_image[cmbd_pkg::IO_REG_MEMORY_CFG] | 8'h01)
                                          : (io_image[cmbd_pkg::IO_REG_MEMORY_CFG] & 8'hFE);
                  cmbd_pkg::IO_REG_LINK_STATUS:
                     rb = r.link_rx_ready ? cmbd_pkg::LINK_STATUS_READY
                                          : cmbd_pkg::LINK_STATUS_IDLE;
                  cmbd_pkg::IO_REG_LINK_DATA: begin
                     o.link_rx_taken = 1'b1;
                     rb = r.link_rx_byte;
                  end
                  cmbd_pkg::IO_REG_ON_KEY:
                     rb = r.on_key_down ? cmbd_pkg::ON_KEY_PRESSED
                                        : cmbd_pkg::ON_KEY_RELEASED;
                  cmbd_pkg::IO_REG_KEYBOARD: rb = r.keyboard_mask;
                  default:                   rb = io_image[io_idx];
               endcase
               rd = {rd[23:0], rb};
            end
         end
      end else begin
         for (int k = 0; k < n; k++) begin
            s  = locate(r.address + 24'(k), model_ram_small, model_rom_mask);
            wb = r.write_data[8*(n-1-k) +: 8];
            // Bytes that spill into bank three use the IO entries as plain
            // storage, with neither side effects nor patched values.
            if (r.command == cmbd_pkg::CMD_WRITE) begin
               case (s.tgt)
                  cmbd_pkg::TGT_RAM: ram_image[s.idx] = wb;
                  cmbd_pkg::TGT_ROM: rom_image[s.idx] = wb;
                  default: io_image[s.idx[cmbd_pkg::IO_OFFSET_WIDTH-1:0]] = wb;
               endcase
            end else begin
               case (s.tgt)
                  cmbd_pkg::TGT_RAM: rb = ram_image[s.idx];
                  cmbd_pkg::TGT_ROM: rb = rom_image[s.idx];
                  default: rb = io_image[s.idx[cmbd_pkg::IO_OFFSET_WIDTH-1:0]];
               endcase
               rd = {rd[23:0], rb};
            end
         end
      end
      if (r.command == cmbd_pkg::CMD_WRITE) rd = '0;
      o.read_data = rd;
      return o;
   endfunction

   // Queues one transaction with random link and keyboard inputs. A read
   // that would touch a RAM or ROM byte never written is turned into a write
   // of the same shape, which fills those bytes for later reads.
   task automatic plan_access(input logic cmd, input logic [1:0] size,
                              input logic [23:0] addr, input logic [31:0] data);
      cmbd_pkg::req_type r;
      slot_type          s;
      int                n;
      bit                known;
      logic              c;
      c     = cmd;
      n     = byte_count(size);
      known = 1'b1;
      if (!(n > 1 && addr[0]) && addr < cmbd_pkg::IO_BASE) begin
         for (int k = 0; k < n; k++) begin
            s = locate(addr + 24'(k), plan_ram_small, plan_rom_mask);
            if (s.tgt == cmbd_pkg::TGT_RAM && !ram_filled[s.idx]) known = 1'b0;
            if (s.tgt == cmbd_pkg::TGT_ROM && !rom_filled[s.idx]) known = 1'b0;
         end
         if (c != cmbd_pkg::CMD_WRITE && !known) c = cmbd_pkg::CMD_WRITE;
         if (c == cmbd_pkg::CMD_WRITE) begin
            for (int k = 0; k < n; k++) begin
               s = locate(addr + 24'(k), plan_ram_small, plan_rom_mask);
               if (s.tgt == cmbd_pkg::TGT_RAM) ram_filled[s.idx] = 1'b1;
               if (s.tgt == cmbd_pkg::TGT_ROM) rom_filled[s.idx] = 1'b1;
            end
            recent_writes.push_back(addr);
            if (recent_writes.size() > RECENT_DEPTH) void'(recent_writes.pop_front());
         end
      end
      r.command       = c;
      r.access_size   = size;
      r.address       = addr;
      r.write_data    = data;
      r.link_rx_ready = 1'($urandom_range(1));
      r.link_rx_byte  = 8'($urandom);
      r.on_key_down   = 1'($urandom_range(1));
      r.keyboard_mask = 8'($urandom);
      bus_requests.push_back(r);
      items_made++;
   endtask

   // Waits until every queued transaction has been accepted and answered,
   // then lets the unit settle.
   task automatic wait_until_quiet();
      while (items_accepted != items_made || due_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes one configuration register through its own handshake. Only
   // called while the unit is idle.
   task automatic write_register(input logic [cmbd_pkg::CSR_INDEX_WIDTH-1:0] index,
                                 input logic [cmbd_pkg::CSR_DATA_WIDTH-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (index)
         cmbd_pkg::CSR_RAM_IS_SMALL:     plan_ram_small = value[0];
         cmbd_pkg::CSR_ROM_ADDRESS_MASK: plan_rom_mask  = value;
         default: ;
      endcase
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display("mismatch on response %0d: %s is %h, %h was due", results_checked, what,
                  got, want);
   endtask

   task automatic check_field(input string what, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want) report_mismatch(what, got, want);
   endtask

   // Request driver. A free slot is filled from the pending queue unless the
   // sender idles this cycle; an offered transaction is held until taken. The
   // expected response is worked out at the edge that accepts it.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            due_results.push_back(serve_access(req_data));
            items_accepted++;
         end
         if (!req_valid || req_ready) begin
            if (bus_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_data  <= bus_requests.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Response ready. Once, early in the run, the receiver holds off for a
   // long stretch while the sender keeps offering, so that the unit fills up
   // and has to stall its request side.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (!hold_started && results_checked >= HOLD_AFTER) begin
            hold_started = 1'b1;
            hold_left    = HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // Response monitor: every accepted response is compared field by field
   // with the oldest one due.
   always @(posedge clock) begin
      cmbd_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (due_results.size() == 0) begin
            report_mismatch("response with none due, read_data", rsp_data.read_data, '0);
         end else begin
            want = due_results.pop_front();
            check_field("read_data", rsp_data.read_data, want.read_data);
            check_field("address_error", 32'(rsp_data.address_error),
                        32'(want.address_error));
            check_field("raise_interrupt_four", 32'(rsp_data.raise_interrupt_four),
                        32'(want.raise_interrupt_four));
            check_field("link_tx_valid", 32'(rsp_data.link_tx_valid),
                        32'(want.link_tx_valid));
            check_field("link_tx_byte", 32'(rsp_data.link_tx_byte),
                        32'(want.link_tx_byte));
            check_field("link_rx_taken", 32'(rsp_data.link_rx_taken),
                        32'(want.link_rx_taken));
            check_field("timer_write_valid", 32'(rsp_data.timer_write_valid),
                        32'(want.timer_write_valid));
            check_field("timer_write_value", 32'(rsp_data.timer_write_value),
                        32'(want.timer_write_value));
            check_field("contrast_changed", 32'(rsp_data.contrast_changed),
                        32'(want.contrast_changed));
            check_field("screen_base_changed", 32'(rsp_data.screen_base_changed),
                        32'(want.screen_base_changed));
            if (want.address_error) errors_seen++;
            if (want.raise_interrupt_four || want.link_tx_valid || want.link_rx_taken ||
                want.timer_write_valid || want.contrast_changed || want.screen_base_changed)
               side_effects++;
         end
         results_checked++;
      end
   end

   // The configuration image follows the register writes as they are taken.
   always @(posedge clock) begin
      if (!reset && csr_valid && csr_ready) begin
         csr_writes++;
         case (csr_index)
            cmbd_pkg::CSR_RAM_IS_SMALL:     model_ram_small = csr_data[0];
            cmbd_pkg::CSR_ROM_ADDRESS_MASK: model_rom_mask  = csr_data;
            default: ;
         endcase
      end
   end

   // Counts cycles in which no transaction of any channel completes.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      wait (quiet_cycles >= WATCHDOG_LIMIT);
      $display("watchdog: no transaction completed for %0d cycles", WATCHDOG_LIMIT);
      $display("end of test: mismatches");
      $finish;
   end

   // Stimulus. Phase zero runs on the reset configuration and opens with the
   // directed transactions; each later phase first rewrites both registers.
   // The first two phases let the sender idle lightly and the receiver
   // heavily, the next two the other way round, the last two idle neither.
   initial begin
      logic [23:0] hot_base [9];
      logic [4:0]  io_pick [14];
      logic        small_plan [PHASES];
      logic [19:0] mask_plan [PHASES];
      logic [19:0] mask;
      logic [23:0] addr;
      logic [1:0]  size;
      logic        cmd;
      int          kind;
      hot_base   = '{24'h000000, 24'h01FFF8, 24'h03FFF8, 24'h1FFFF8, 24'h200000,
                     24'h2FFFF8, 24'h3FFFF8, 24'h4FFF00, 24'h5FFFF8};
      io_pick    = '{5'h00, 5'h01, 5'h0c, 5'h0d, 5'h0e, 5'h0f, 5'h10,
                     5'h11, 5'h17, 5'h1a, 5'h1b, 5'h1c, 5'h1d, 5'h1e};
      small_plan = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
      mask_plan  = '{20'hFFFFF, 20'hFFFFF, 20'h00000, 20'h00FFF, 20'h00000, 20'h7FFFF};

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int phase = 0; phase < PHASES; phase++) begin
         if (phase > 0) begin
            wait_until_quiet();
            // The upper bits of the RAM size register carry random junk.
            write_register(cmbd_pkg::CSR_RAM_IS_SMALL, {19'($urandom), small_plan[phase]});
            mask = (phase == 4) ? 20'($urandom) : mask_plan[phase];
            write_register(cmbd_pkg::CSR_ROM_ADDRESS_MASK, mask);
         end
         send_idle_pct = (phase < 2) ? 26 : (phase < 4) ? 75 : 0;
         recv_idle_pct = (phase < 2) ? 75 : (phase < 4) ? 26 : 0;

         if (phase == 0) begin
            // Plain RAM bytes, words and longs, written and read back.
            plan_access(cmbd_pkg::CMD_WRITE, cmbd_pkg::SIZE_BYTE, 24'h000000, 32'h000000A5);
            plan_access(CMD_READ,            cmbd_pkg::SIZE_BYTE, 24'h000000, 32'h0);
            plan_access(cmbd_pkg::CMD_WRITE, cmbd_pkg::SIZE_WORD, 24'h000002, 32'h00001234);
            plan_access(cmbd_pkg::CMD_WRITE, SIZE_LONG, 24'h000004, 32'hFFFFFFFF);
            plan_access(CMD_READ,            SIZE_LONG, 24'h000004, 32'h0);
            plan_access(CMD_READ,            cmbd_pkg::SIZE_WORD, 24'h000002, 32'h0);
            // Odd word read and odd long write: address error, nothing stored.
            plan_access(CMD_READ,            cmbd_pkg::SIZE_WORD, 24'h000003, 32'h0);
            plan_access(cmbd_pkg::CMD_WRITE, SIZE_LONG, 24'h000005, 32'h0);
            // Size code three behaves as a long.
            plan_access(cmbd_pkg::CMD_WRITE, SIZE_THREE, 24'h000010, 32'hCAFEF00D);
            plan_access(CMD_READ,            SIZE_THREE, 24'h000010, 32'h0);
            // Longs that straddle RAM and ROM, the two ROM banks, and ROM and
            // the raw IO entries.
            plan_access(cmbd_pkg::CMD_WRITE, SIZE_LONG, 24'h1FFFFE, 32'h11223344);
            plan_access(CMD_READ,            SIZE_LONG, 24'h1FFFFE, 32'h0);
            plan_access(cmbd_pkg::CMD_WRITE, SIZE_LONG, 24'h3FFFFE, 32'h55667788);
            plan_access(CMD_READ,            SIZE_LONG, 24'h3FFFFE, 32'h0);
            plan_access(cmbd_pkg::CMD_WRITE, SIZE_LONG, 24'h5FFFFE, 32'h99AABBCC);
            plan_access(CMD_READ,            SIZE_LONG, 24'h5FFFFE, 32'h0);
            // IO registers with patched reads and write side effects.
            plan_access(CMD_READ,            SIZE_LONG, 24'h600000, 32'h0);
            plan_access(cmbd_pkg::CMD_WRITE, cmbd_pkg::SIZE_BYTE, 24'h60000C, 32'h00000002);
            plan_access(cmbd_pkg::CMD_WRITE, cmbd_pkg::SIZE_WORD, 24'h60000E, 32'h0000ABCD);
            plan_access(CMD_READ,            SIZE_LONG, 24'h60000C, 32'h0);
            plan_access(cmbd_pkg::CMD_WRITE, SIZE_LONG, 24'h600014, 32'h01020304);
            plan_access(cmbd_pkg::CMD_WRITE, cmbd_pkg::SIZE_WORD, 24'h600010, 32'h0000BEEF);
            plan_access(CMD_READ,            SIZE_LONG, 24'h600018, 32'h0);
            // A long that runs past the last IO register into the spare
            // entries, then the top of the address space.
            plan_access(cmbd_pkg::CMD_WRITE, SIZE_LONG, 24'h60001E, 32'hDEADBEEF);
            plan_access(CMD_READ,            SIZE_LONG, 24'h60001E, 32'h0);
            plan_access(cmbd_pkg::CMD_WRITE, cmbd_pkg::SIZE_BYTE, 24'hFFFFFD, 32'hFFFFFFFF);
            plan_access(CMD_READ,            cmbd_pkg::SIZE_BYTE, 24'hFFFFFF, 32'h0);
         end

         for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
            kind = $urandom_range(99);
            size = 2'($urandom_range(3));
            cmd  = 1'($urandom_range(1));
            if (kind < 40) begin
               // Near the bank edges and aliasing points, so reads find data.
               addr = hot_base[$urandom_range(8)] + 24'($urandom_range(15));
               if (size != cmbd_pkg::SIZE_BYTE && $urandom_range(15) != 0) addr[0] = 1'b0;
            end else if (kind < 70) begin
               // Read back somewhere written lately, in any size.
               cmd = CMD_READ;
               if (recent_writes.size() != 0)
                  addr = recent_writes[$urandom_range(recent_writes.size() - 1)];
               else
                  addr = hot_base[0];
               if (size != cmbd_pkg::SIZE_BYTE) addr[0] = 1'b0;
            end else if (kind < 85) begin
               addr = 24'($urandom_range(24'hFFFFFF, cmbd_pkg::IO_BASE));
               if ($urandom_range(1)) addr[4:0] = io_pick[$urandom_range(13)];
               if (size != cmbd_pkg::SIZE_BYTE && $urandom_range(15) != 0) addr[0] = 1'b0;
            end else if (kind < 93) begin
               size = 2'($urandom_range(3, 1));
               addr = 24'($urandom) | 24'h000001;
            end else begin
               cmd  = cmbd_pkg::CMD_WRITE;
               addr = 24'($urandom);
            end
            plan_access(cmd, size, addr, $urandom);
         end
         wait_until_quiet();
      end

      $display("run covered %0d bus transactions and %0d register writes over %0d phases",
               results_checked, csr_writes, PHASES);
      $display("of these %0d gave address errors and %0d had IO side effects",
               errors_seen, side_effects);
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
